// File: src/fbts_pkg.sv
`timescale 1ns / 1ps

package fbts_pkg;

    // Fixed field widths of the detection record and the result.
    localparam int COORD_W  = 18;
    localparam int SCORE_W  = 16;
    localparam int FACE_W   = 6;
    localparam int KEPT_W   = 7;
    localparam int MAXF_W   = 7;
    localparam int IN_DW    = SCORE_W + 4 * COORD_W;

    // Defaults for the top-level parameters.
    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int DIM_BITS_DEF        = 13;

    // Register reset values.
    localparam int CAM_WIDTH_RST  = 640;
    localparam int CAM_HEIGHT_RST = 480;
    localparam logic [SCORE_W-1:0] THRESH_RST    = 16'd45875;
    localparam logic [MAXF_W-1:0]  MAX_FACES_RST = 7'd16;

    // Face counting and box side limits.
    localparam logic [KEPT_W-1:0] FACE_LIMIT = 7'd64;
    localparam int MIN_SIDE_TENTHS = 160;
    localparam int HALF_MIN        = MIN_SIDE_TENTHS / 20;

    typedef enum logic [1:0] {
        CFG_CAM_WIDTH  = 2'd0,
        CFG_CAM_HEIGHT = 2'd1,
        CFG_THRESHOLD  = 2'd2,
        CFG_MAX_FACES  = 2'd3
    } t_cfg_idx;

    // Which rule set the half side of the square box.
    typedef enum logic [1:0] {
        SIDE_MIN   = 2'd0,
        SIDE_CAP   = 2'd1,
        SIDE_SCALE = 2'd2
    } t_side_sel;

    typedef struct packed {
        logic signed [COORD_W-1:0] bottom;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] left;
    } t_corners;

endpackage

// File: src/fbts_admit.sv
`timescale 1ns / 1ps

module fbts_admit #(
    parameter int DIM_BITS = fbts_pkg::DIM_BITS_DEF,
    localparam int CFG_W = (DIM_BITS > fbts_pkg::SCORE_W) ? DIM_BITS : fbts_pkg::SCORE_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  fbts_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_wdata,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_frame_start,
    input  logic [fbts_pkg::SCORE_W-1:0]  i_score,
    input  fbts_pkg::t_corners            i_corners,
    output logic [DIM_BITS-1:0]           o_cam_width,
    output logic [DIM_BITS-1:0]           o_cam_height,
    output logic                          o_valid,
    output logic [fbts_pkg::FACE_W-1:0]   o_face,
    output fbts_pkg::t_corners            o_corners
);
    import fbts_pkg::*;

    logic [DIM_BITS-1:0] r_cam_width;
    logic [DIM_BITS-1:0] r_cam_height;
    logic [SCORE_W-1:0]  r_thresh;
    logic [MAXF_W-1:0]   r_max_faces;
    logic [KEPT_W-1:0]   r_kept;
    logic [KEPT_W-1:0]   n_kept;
    logic                r_valid;
    logic [FACE_W-1:0]   r_face;
    t_corners            r_corners;

    logic [KEPT_W-1:0] limit;
    logic [KEPT_W-1:0] kept_base;
    logic              keep;
    logic              acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_width  <= DIM_BITS'(CAM_WIDTH_RST);
            r_cam_height <= DIM_BITS'(CAM_HEIGHT_RST);
            r_thresh     <= THRESH_RST;
            r_max_faces  <= MAX_FACES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAM_WIDTH:  r_cam_width  <= i_cfg_wdata[DIM_BITS-1:0];
                CFG_CAM_HEIGHT: r_cam_height <= i_cfg_wdata[DIM_BITS-1:0];
                CFG_THRESHOLD:  r_thresh     <= i_cfg_wdata[SCORE_W-1:0];
                CFG_MAX_FACES:  r_max_faces  <= i_cfg_wdata[MAXF_W-1:0];
            endcase
        end
    end

    // The frame-start flag clears the count before this record is judged.
    assign limit     = (r_max_faces > FACE_LIMIT) ? FACE_LIMIT : r_max_faces;
    assign kept_base = i_frame_start ? '0 : r_kept;
    assign keep      = (i_score > r_thresh) && (kept_base < limit);
    assign acc       = i_valid && i_en;
    assign n_kept    = keep ? kept_base + KEPT_W'(1) : kept_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_kept <= n_kept;
            end
            if (i_en) begin
                r_valid <= acc && keep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_face    <= kept_base[FACE_W-1:0];
            r_corners <= i_corners;
        end
    end

    assign o_cam_width  = r_cam_width;
    assign o_cam_height = r_cam_height;
    assign o_valid      = r_valid;
    assign o_face       = r_face;
    assign o_corners    = r_corners;

    a_kept_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= FACE_LIMIT)
        else $error("face count above the per-frame limit");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_frame_start) |=> (r_kept <= KEPT_W'(1)))
        else $error("frame start did not clear the face count");

    a_kept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_kept))
        else $error("face count moved without an accepted word");

endmodule

// File: src/fbts_scale.sv
`timescale 1ns / 1ps

module fbts_scale #(
    parameter int COORD_FRAC_BITS = fbts_pkg::COORD_FRAC_BITS_DEF,
    parameter int DIM_BITS        = fbts_pkg::DIM_BITS_DEF,
    localparam int PRW = fbts_pkg::COORD_W + DIM_BITS,
    localparam int PW  = PRW - COORD_FRAC_BITS + 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [fbts_pkg::COORD_W-1:0]  i_coord,
    input  logic [DIM_BITS-1:0]                  i_cam,
    output logic signed [PW-1:0]                 o_pixel
);
    import fbts_pkg::*;

    logic [COORD_W-1:0]   mag;
    logic [PRW-1:0]       prod;
    logic [PRW-1:0]       r_prod;
    logic                 r_neg;
    logic signed [PW-1:0] mag_pix;
    logic signed [PW-1:0] r_pixel;

    // Scale the magnitude so that the shift truncates toward zero.
    assign mag  = i_coord[COORD_W-1] ? COORD_W'(-i_coord) : i_coord;
    assign prod = PRW'(mag) * PRW'(i_cam);

    assign mag_pix = signed'({1'b0, r_prod[PRW-1:COORD_FRAC_BITS]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= prod;
            r_neg   <= i_coord[COORD_W-1];
            r_pixel <= r_neg ? -mag_pix : mag_pix;
        end
    end

    assign o_pixel = r_pixel;

endmodule

// File: src/fbts_box.sv
`timescale 1ns / 1ps

module fbts_box #(
    parameter int COORD_FRAC_BITS = fbts_pkg::COORD_FRAC_BITS_DEF,
    parameter int DIM_BITS        = fbts_pkg::DIM_BITS_DEF,
    localparam int PW = fbts_pkg::COORD_W + DIM_BITS - COORD_FRAC_BITS + 1
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [PW-1:0]   i_x1,
    input  logic signed [PW-1:0]   i_y1,
    input  logic signed [PW-1:0]   i_x2,
    input  logic signed [PW-1:0]   i_y2,
    input  logic [DIM_BITS-1:0]    i_cam_width,
    input  logic [DIM_BITS-1:0]    i_cam_height,
    output fbts_pkg::t_side_sel    o_sel,
    output logic [DIM_BITS-1:0]    o_quot,
    output logic signed [PW-1:0]   o_cx,
    output logic signed [PW-1:0]   o_cy
);
    import fbts_pkg::*;

    localparam int GW  = PW + 1;
    localparam int TW  = (GW + 3 > DIM_BITS + 5) ? GW + 3 : DIM_BITS + 5;
    localparam int CPW = DIM_BITS + 4;
    localparam int MW  = DIM_BITS + 1;
    localparam int NB  = DIM_BITS + 2;
    localparam int SH  = DIM_BITS + 4;
    localparam int QPW = 2 * DIM_BITS + 4;
    // Reciprocal of 5, rounded up; exact for every numerator below 2^NB.
    localparam logic [NB-1:0] RECIP = NB'(((1 << SH) + 4) / 5);

    logic signed [GW-1:0]  w;
    logic signed [GW-1:0]  h;
    logic signed [GW-1:0]  m;
    logic signed [GW-1:0]  sx;
    logic signed [GW-1:0]  sy;
    logic signed [GW-1:0]  sx_adj;
    logic signed [GW-1:0]  sy_adj;
    logic signed [TW-1:0]  t;
    logic signed [TW-1:0]  cap_s;
    logic [DIM_BITS-1:0]   cmin;
    logic [CPW-1:0]        cap;
    logic                  over_cap;
    logic                  cap_lo;
    logic                  t_lo;
    t_side_sel             sel;
    logic [QPW-1:0]        qprod;

    t_side_sel             r_sel4;
    logic [MW-1:0]         r_m4;
    logic signed [PW-1:0]  r_cx4;
    logic signed [PW-1:0]  r_cy4;
    t_side_sel             r_sel5;
    logic [DIM_BITS-1:0]   r_quot5;
    logic signed [PW-1:0]  r_cx5;
    logic signed [PW-1:0]  r_cy5;

    assign w = GW'(i_x2) - GW'(i_x1) + GW'(1);
    assign h = GW'(i_y2) - GW'(i_y1) + GW'(1);
    assign m = (w > h) ? w : h;

    // Centers: halve the sum, truncating toward zero.
    assign sx     = GW'(i_x1) + GW'(i_x2);
    assign sy     = GW'(i_y1) + GW'(i_y2);
    assign sx_adj = sx + $signed(GW'(sx[GW-1]));
    assign sy_adj = sy + $signed(GW'(sy[GW-1]));

    // The side in tenths of a pixel is 8 * max(w, h).
    assign t     = TW'(m) <<< 3;
    assign cmin  = (i_cam_width < i_cam_height) ? i_cam_width : i_cam_height;
    assign cap   = (CPW'(cmin) << 3) + (CPW'(cmin) << 1);
    assign cap_s = signed'(TW'(cap));

    assign over_cap = t > cap_s;
    assign cap_lo   = cap < CPW'(MIN_SIDE_TENTHS);
    assign t_lo     = t < TW'(MIN_SIDE_TENTHS);

    always_comb begin
        priority if (over_cap && cap_lo) begin
            sel = SIDE_MIN;
        end else if (over_cap) begin
            sel = SIDE_CAP;
        end else if (t_lo) begin
            sel = SIDE_MIN;
        end else begin
            sel = SIDE_SCALE;
        end
    end

    // half = 8m / 20 = 2m / 5 on the scaled path.
    assign qprod = QPW'({r_m4, 1'b0}) * QPW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel4  <= sel;
            r_m4    <= MW'(unsigned'(m));
            r_cx4   <= PW'(sx_adj >>> 1);
            r_cy4   <= PW'(sy_adj >>> 1);
            r_sel5  <= r_sel4;
            r_quot5 <= qprod[QPW-1:SH];
            r_cx5   <= r_cx4;
            r_cy5   <= r_cy4;
        end
    end

    assign o_sel  = r_sel5;
    assign o_quot = r_quot5;
    assign o_cx   = r_cx5;
    assign o_cy   = r_cy5;

endmodule

// File: src/fbts_place.sv
`timescale 1ns / 1ps

module fbts_place #(
    parameter int COORD_FRAC_BITS = fbts_pkg::COORD_FRAC_BITS_DEF,
    parameter int DIM_BITS        = fbts_pkg::DIM_BITS_DEF,
    localparam int PW = fbts_pkg::COORD_W + DIM_BITS - COORD_FRAC_BITS + 1
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  fbts_pkg::t_side_sel   i_sel,
    input  logic [DIM_BITS-1:0]   i_quot,
    input  logic signed [PW-1:0]  i_cx,
    input  logic signed [PW-1:0]  i_cy,
    input  logic [DIM_BITS-1:0]   i_cam_width,
    input  logic [DIM_BITS-1:0]   i_cam_height,
    output logic [DIM_BITS-1:0]   o_left,
    output logic [DIM_BITS-1:0]   o_top,
    output logic [DIM_BITS-1:0]   o_right,
    output logic [DIM_BITS-1:0]   o_bottom
);
    import fbts_pkg::*;

    localparam int XW = ((PW > DIM_BITS + 1) ? PW : DIM_BITS + 1) + 2;

    logic [DIM_BITS-1:0]   cmin;
    logic [DIM_BITS-1:0]   half;
    logic [2*DIM_BITS-1:0] x_span;
    logic [2*DIM_BITS-1:0] y_span;
    logic [DIM_BITS-1:0]   r_left;
    logic [DIM_BITS-1:0]   r_top;
    logic [DIM_BITS-1:0]   r_right;
    logic [DIM_BITS-1:0]   r_bottom;

    // Pushes one axis of the box back into the frame; returns {high, low} edges.
    // The high-edge correction is applied first, then the low-edge one.
    function automatic logic [2*DIM_BITS-1:0] place_axis(
        input logic signed [PW-1:0] c,
        input logic [DIM_BITS-1:0]  hv,
        input logic [DIM_BITS-1:0]  dim
    );
        logic signed [XW-1:0] cc;
        logic signed [XW-1:0] hh;
        logic signed [XW-1:0] dd;
        logic signed [XW-1:0] lo_a;
        logic signed [XW-1:0] hi_a;
        logic signed [XW-1:0] lo1;
        logic signed [XW-1:0] hi1;
        logic signed [XW-1:0] lo;
        logic signed [XW-1:0] hi;
        logic                 over;
        logic                 under;
        cc    = XW'(c);
        hh    = signed'(XW'(hv));
        dd    = signed'(XW'(dim));
        lo_a  = cc - hh;
        hi_a  = cc + hh;
        over  = hi_a >= dd;
        lo1   = over ? dd - hh - hh - XW'(1) : lo_a;
        hi1   = over ? dd - XW'(1) : hi_a;
        under = lo1 < XW'(0);
        lo    = under ? XW'(0) : lo1;
        hi    = under ? hh + hh : hi1;
        return {DIM_BITS'(hi), DIM_BITS'(lo)};
    endfunction

    assign cmin = (i_cam_width < i_cam_height) ? i_cam_width : i_cam_height;

    always_comb begin
        unique case (i_sel)
            SIDE_MIN:   half = DIM_BITS'(HALF_MIN);
            SIDE_CAP:   half = cmin >> 1;
            SIDE_SCALE: half = i_quot;
            default:    half = i_quot;
        endcase
    end

    assign x_span = place_axis(i_cx, half, i_cam_width);
    assign y_span = place_axis(i_cy, half, i_cam_height);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_left   <= x_span[DIM_BITS-1:0];
            r_right  <= x_span[2*DIM_BITS-1:DIM_BITS];
            r_top    <= y_span[DIM_BITS-1:0];
            r_bottom <= y_span[2*DIM_BITS-1:DIM_BITS];
        end
    end

    assign o_left   = r_left;
    assign o_top    = r_top;
    assign o_right  = r_right;
    assign o_bottom = r_bottom;

endmodule

// File: src/face_box_threshold_squarer.sv
`timescale 1ns / 1ps

// Face box threshold squarer.
//
// Each input word on the slave stream is one detection record. tdata carries
// the score and the four normalized corners, tuser carries the frame-start
// flag, which clears the per-frame face count before the record is judged.
// A record scoring strictly above the threshold, while fewer than max_faces
// faces (at most 64) were kept in the frame, produces one output word: the
// face number and a square pixel box clamped into the camera frame. Other
// records produce nothing.
//
// The pipeline takes one word per clock cycle while the holding register is
// empty. Its depth is set by the input register, the corner multipliers (two
// stages), the side selection, the divide-by-five reciprocal multiply and
// the clamp stage.
//
// Reset clears the face count and pipeline and loads register defaults. The
// user must write registers only while the stream is idle; the block does
// not enforce it. A refused output word goes to a one-word holding register;
// from the next cycle the pipeline holds and slave tready is low until taken.
module face_box_threshold_squarer #(
    parameter int COORD_FRAC_BITS = fbts_pkg::COORD_FRAC_BITS_DEF,
    parameter int DIM_BITS        = fbts_pkg::DIM_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port.
    input  logic                        i_cfg_we,
    input  fbts_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [((DIM_BITS > fbts_pkg::SCORE_W) ? DIM_BITS : fbts_pkg::SCORE_W)-1:0]
                                        i_cfg_wdata,
    // Slave stream.
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata from bit 0: score, left_norm, top_norm, right_norm, bottom_norm.
    input  logic [fbts_pkg::IN_DW-1:0]  i_s_axis_tdata,
    // tuser: frame_start.
    input  logic                        i_s_axis_tuser,
    // Master stream.
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // tdata from bit 0: face_number, square_left, square_top, square_right,
    // square_bottom, then zero fill.
    output logic [((fbts_pkg::FACE_W + 4 * DIM_BITS + 7) / 8) * 8 - 1:0]
                                        o_m_axis_tdata
);
    import fbts_pkg::*;

    localparam int PW     = COORD_W + DIM_BITS - COORD_FRAC_BITS + 1;
    localparam int OUT_DW = ((FACE_W + 4 * DIM_BITS + 7) / 8) * 8;
    // Stages after the input register: two scale, two box, one output.
    localparam int NSTG   = 5;

    logic                  en;
    t_corners              in_corners;
    t_corners              s1_corners;
    logic                  s1_valid;
    logic [FACE_W-1:0]     s1_face;
    logic [DIM_BITS-1:0]   cam_width;
    logic [DIM_BITS-1:0]   cam_height;
    logic signed [PW-1:0]  px_left;
    logic signed [PW-1:0]  px_top;
    logic signed [PW-1:0]  px_right;
    logic signed [PW-1:0]  px_bottom;
    t_side_sel             box_sel;
    logic [DIM_BITS-1:0]   box_quot;
    logic signed [PW-1:0]  box_cx;
    logic signed [PW-1:0]  box_cy;
    logic [DIM_BITS-1:0]   sq_left;
    logic [DIM_BITS-1:0]   sq_top;
    logic [DIM_BITS-1:0]   sq_right;
    logic [DIM_BITS-1:0]   sq_bottom;
    logic [OUT_DW-1:0]     pipe_data;

    logic [NSTG-1:0]       r_vld;
    logic [FACE_W-1:0]     r_face [NSTG];
    logic                  r_skid_vld;
    logic [OUT_DW-1:0]     r_skid_data;

    // Everything moves together unless the holding register is occupied.
    assign en = !r_skid_vld;
    assign o_s_axis_tready = en;

    assign in_corners.left   = i_s_axis_tdata[SCORE_W +: COORD_W];
    assign in_corners.top    = i_s_axis_tdata[SCORE_W + COORD_W +: COORD_W];
    assign in_corners.right  = i_s_axis_tdata[SCORE_W + 2 * COORD_W +: COORD_W];
    assign in_corners.bottom = i_s_axis_tdata[SCORE_W + 3 * COORD_W +: COORD_W];

    fbts_admit #(
        .DIM_BITS (DIM_BITS)
    ) u_admit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_en          (en),
        .i_valid       (i_s_axis_tvalid),
        .i_frame_start (i_s_axis_tuser),
        .i_score       (i_s_axis_tdata[SCORE_W-1:0]),
        .i_corners     (in_corners),
        .o_cam_width   (cam_width),
        .o_cam_height  (cam_height),
        .o_valid       (s1_valid),
        .o_face        (s1_face),
        .o_corners     (s1_corners)
    );

    fbts_scale #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .DIM_BITS        (DIM_BITS)
    ) u_scale_left (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (s1_corners.left),
        .i_cam   (cam_width),
        .o_pixel (px_left)
    );

    fbts_scale #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .DIM_BITS        (DIM_BITS)
    ) u_scale_top (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (s1_corners.top),
        .i_cam   (cam_height),
        .o_pixel (px_top)
    );

    fbts_scale #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .DIM_BITS        (DIM_BITS)
    ) u_scale_right (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (s1_corners.right),
        .i_cam   (cam_width),
        .o_pixel (px_right)
    );

    fbts_scale #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .DIM_BITS        (DIM_BITS)
    ) u_scale_bottom (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (s1_corners.bottom),
        .i_cam   (cam_height),
        .o_pixel (px_bottom)
    );

    fbts_box #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .DIM_BITS        (DIM_BITS)
    ) u_box (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_x1         (px_left),
        .i_y1         (px_top),
        .i_x2         (px_right),
        .i_y2         (px_bottom),
        .i_cam_width  (cam_width),
        .i_cam_height (cam_height),
        .o_sel        (box_sel),
        .o_quot       (box_quot),
        .o_cx         (box_cx),
        .o_cy         (box_cy)
    );

    fbts_place #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .DIM_BITS        (DIM_BITS)
    ) u_place (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_sel        (box_sel),
        .i_quot       (box_quot),
        .i_cx         (box_cx),
        .i_cy         (box_cy),
        .i_cam_width  (cam_width),
        .i_cam_height (cam_height),
        .o_left       (sq_left),
        .o_top        (sq_top),
        .o_right      (sq_right),
        .o_bottom     (sq_bottom)
    );

    // Valid bits and face numbers ride alongside the datapath stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], s1_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_face[0] <= s1_face;
            for (int i = 1; i < NSTG; i++) begin
                r_face[i] <= r_face[i-1];
            end
        end
    end

    assign pipe_data = OUT_DW'({sq_bottom, sq_right, sq_top, sq_left, r_face[NSTG-1]});

    // The last stage word that the receiver refuses is parked here, so the
    // slave-side tready comes from a register and not from the master side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_m_axis_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[NSTG-1] && !i_m_axis_tready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_data <= pipe_data;
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1] || r_skid_vld;
    assign o_m_axis_tdata  = r_skid_vld ? r_skid_data : pipe_data;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the face box threshold squarer.
//
// Detection records are sent on the slave stream. Each word that the block
// accepts is run through a predictor kept in this file. The predictor holds
// its own copy of the four registers and of the per-frame face count. It
// decides whether the record is kept and, if so, which square box must come
// out. Expected boxes wait in a queue. Every word taken from the master stream
// is compared field by field with the oldest entry.
//
// The run is a sequence of test tasks:
//   - directed records at the register defaults (threshold edges, coordinate
//     extremes, inverted and empty boxes, clamping at every frame edge),
//   - the per-frame face limit, including a limit of zero,
//   - random phases over many register settings, with extremes such as
//     16x16 and 4096x4096 frames, a zero-sized frame, out-of-range widths,
//     and limits above 64,
//   - a long receiver hold-off, so that the pipeline fills and the block
//     stalls its input,
//   - a stretch with no idling on either side.
// Registers are only rewritten once every expected word has arrived and the
// pipeline has had time to flush records that produce no output.
module tb_top;

    import fbts_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int DRAIN_CYCLES  = 20;     // well beyond the pipeline latency
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PERCENT  = 36;
    localparam int BOX_DEPTH     = 64;

    // One detection record, as the block sees it on the slave stream.
    typedef struct {
        logic                      frame_start;
        logic [SCORE_W-1:0]        score;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
    } t_det_rec;

    // One square box, as it should appear on the master stream.
    typedef struct {
        logic [FACE_W-1:0] face;
        logic [12:0]       sq_left;
        logic [12:0]       sq_top;
        logic [12:0]       sq_right;
        logic [12:0]       sq_bottom;
    } t_sq_box;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [15:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // Fields from bit 0: score, left_norm, top_norm, right_norm, bottom_norm.
    logic [IN_DW-1:0] i_s_axis_tdata;
    // Field: frame_start.
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // Fields from bit 0: face_number, square_left, square_top, square_right,
    // square_bottom, then zero fill.
    logic [63:0] o_m_axis_tdata;

    face_box_threshold_squarer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Predictor copy of the registers and the face count, at reset values.
    logic [12:0]        m_cam_w     = 13'(CAM_WIDTH_RST);
    logic [12:0]        m_cam_h     = 13'(CAM_HEIGHT_RST);
    logic [SCORE_W-1:0] m_thresh    = THRESH_RST;
    logic [MAXF_W-1:0]  m_max_faces = MAX_FACES_RST;
    logic [KEPT_W-1:0]  m_kept      = '0;

    // Boxes still owed by the block, oldest at box_rd.
    t_sq_box box_mem [BOX_DEPTH];
    int      box_wr       = 0;
    int      box_rd       = 0;
    int      error_count  = 0;
    int      cycle_count  = 0;
    bit      send_idle_en = 1'b1;
    bit      recv_idle_en = 1'b1;
    bit      hold_start   = 1'b0;
    int      hold_left;

    task automatic report_mismatch(string what, longint want, longint got);
        $display("ERROR at %0t: %s expected %0d, got %0d", $realtime, what, want, got);
        error_count++;
    endtask

    // Scale one normalized corner to pixels, truncating toward zero.
    function automatic longint scale_px(logic signed [COORD_W-1:0] v, longint cam);
        longint sv;
        longint mag;
        longint p;
        sv  = v;
        mag = (sv < 0) ? -sv : sv;
        p   = (mag * cam) >>> COORD_FRAC_BITS_DEF;
        return (sv < 0) ? -p : p;
    endfunction

    // Push a box center back so that the box lies inside [0, dim).
    function automatic longint fit_center(longint c, longint half, longint dim);
        if (c + half >= dim)
            c = dim - half - 1;
        if (c - half < 0)
            c = half;
        return c;
    endfunction

    // Judge one accepted record and work out its square box. Updates the
    // predictor's face count. Returns 1 when the record is kept.
    function automatic bit predict_square(input t_det_rec r, output t_sq_box b);
        longint x1, y1, x2, y2, w, h, m, cx, cy, t, cap, half, cw, ch;
        int     lim;
        b   = '{default: '0};
        cw  = m_cam_w;
        ch  = m_cam_h;
        lim = (m_max_faces > FACE_LIMIT) ? int'(FACE_LIMIT) : int'(m_max_faces);
        if (r.frame_start)
            m_kept = '0;
        if (r.score <= m_thresh || int'(m_kept) >= lim)
            return 1'b0;
        x1 = scale_px(r.left, cw);
        y1 = scale_px(r.top, ch);
        x2 = scale_px(r.right, cw);
        y2 = scale_px(r.bottom, ch);
        w  = x2 - x1 + 1;
        h  = y2 - y1 + 1;
        cx = (x1 + x2) / 2;
        cy = (y1 + y2) / 2;
        // The side is held in tenths of a pixel: 0.8 * max(w, h) is 8 * max.
        m   = (w > h) ? w : h;
        t   = m * 8;
        cap = 10 * ((cw < ch) ? cw : ch);
        if (t > cap)
            t = cap;
        if (t < MIN_SIDE_TENTHS)
            t = MIN_SIDE_TENTHS;
        half = t / 20;
        cx = fit_center(cx, half, cw);
        cy = fit_center(cy, half, ch);
        b.face      = m_kept[FACE_W-1:0];
        b.sq_left   = 13'(cx - half);
        b.sq_top    = 13'(cy - half);
        b.sq_right  = 13'(cx + half);
        b.sq_bottom = 13'(cy + half);
        m_kept = m_kept + 1'b1;
        return 1'b1;
    endfunction

    function automatic t_det_rec mk_rec(logic fs, int unsigned score,
                                        int l, int t, int r, int b);
        t_det_rec rec;
        rec.frame_start = fs;
        rec.score       = 16'(score);
        rec.left        = 18'(l);
        rec.top         = 18'(t);
        rec.right       = 18'(r);
        rec.bottom      = 18'(b);
        return rec;
    endfunction

    // Random record. Most are boxes that start inside the normalized frame and
    // mostly score above the threshold; some are inverted; the rest are noise
    // over the full range of every field.
    function automatic t_det_rec random_record(int fs_one_in);
        t_det_rec r;
        longint   x1, y1, x2, y2, tmp;
        int       roll;
        roll = $urandom_range(0, 99);
        r.frame_start = (fs_one_in > 0) && ($urandom_range(1, fs_one_in) == 1);
        if (roll < 88) begin
            if ($urandom_range(0, 3) != 0 && m_thresh != 16'hFFFF)
                r.score = 16'($urandom_range(int'(m_thresh) + 1, 65535));
            else
                r.score = 16'($urandom);
            x1 = $urandom_range(0, 65536);
            y1 = $urandom_range(0, 65536);
            x2 = x1 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 65536)
                                                   : $urandom_range(0, 9000));
            y2 = y1 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 65536)
                                                   : $urandom_range(0, 9000));
            if (x2 > 131071)
                x2 = 131071;
            if (y2 > 131071)
                y2 = 131071;
            if (roll >= 78) begin
                tmp = x1; x1 = x2; x2 = tmp;
                tmp = y1; y1 = y2; y2 = tmp;
            end
            r.left   = 18'(x1);
            r.top    = 18'(y1);
            r.right  = 18'(x2);
            r.bottom = 18'(y2);
        end else begin
            r.score  = 16'($urandom);
            r.left   = 18'($urandom);
            r.top    = 18'($urandom);
            r.right  = 18'($urandom);
            r.bottom = 18'($urandom);
        end
        return r;
    endfunction

    // Offer one record after a random gap and hold it until the block takes
    // the word. The prediction is made at the accepting edge.
    task automatic send_record(input t_det_rec r);
        t_sq_box b;
        while (send_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r.bottom, r.right, r.top, r.left, r.score};
        i_s_axis_tuser  <= r.frame_start;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        if (predict_square(r, b)) begin
            box_mem[box_wr % BOX_DEPTH] = b;
            box_wr++;
        end
    endtask

    // Stop sending, wait for every owed word, then let the pipeline flush
    // records that were dropped and so leave nothing to wait for.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (box_wr != box_rd)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges. Only called while idle.
    task automatic set_config(logic [15:0] cw, logic [15:0] ch,
                              logic [15:0] thr, logic [15:0] mf);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_CAM_WIDTH;
        i_cfg_wdata <= cw;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_CAM_HEIGHT;
        i_cfg_wdata <= ch;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_THRESHOLD;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_MAX_FACES;
        i_cfg_wdata <= mf;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        m_cam_w     = cw[12:0];
        m_cam_h     = ch[12:0];
        m_thresh    = thr;
        m_max_faces = mf[MAXF_W-1:0];
    endtask

    task automatic run_phase(logic [15:0] cw, logic [15:0] ch, logic [15:0] thr,
                             logic [15:0] mf, int count, int fs_one_in);
        wait_drained();
        set_config(cw, ch, thr, mf);
        repeat (count) send_record(random_record(fs_one_in));
    endtask

    // Register defaults: threshold edges, coordinate extremes and clamping.
    task automatic test_threshold_and_corners();
        // A score equal to the threshold is dropped; one above it is kept.
        send_record(mk_rec(1'b1, 45875, 0, 0, 32768, 32768));
        send_record(mk_rec(1'b0, 45876, 16384, 16384, 32768, 32768));
        send_record(mk_rec(1'b0, 0, 16384, 16384, 32768, 32768));
        // Whole frame: the side is capped by the smaller camera dimension.
        send_record(mk_rec(1'b0, 65535, 0, 0, 65535, 65535));
        // Empty box at the origin: minimum side, pushed off the low edges.
        send_record(mk_rec(1'b0, 65535, 0, 0, 0, 0));
        // Largest positive corners: pushed back from the high edges.
        send_record(mk_rec(1'b0, 65535, 131071, 131071, 131071, 131071));
        // Most negative corners everywhere.
        send_record(mk_rec(1'b0, 65535, -131072, -131072, -131072, -131072));
        // Inverted box: negative width and height fall to the minimum side.
        send_record(mk_rec(1'b0, 65535, 49152, 49152, 16384, 16384));
        // Corners at both extremes of the signed range.
        send_record(mk_rec(1'b0, 65535, -131072, -131072, 131071, 131071));
        // Zero width, full height.
        send_record(mk_rec(1'b0, 65535, 65535, 0, 65535, 65535));
        // Tiny box straddling zero, where truncation toward zero matters.
        send_record(mk_rec(1'b0, 65535, -1, -3, 1, 3));
        // New frame: the face number starts over.
        send_record(mk_rec(1'b1, 65535, 32768, 32768, 32800, 32800));
    endtask

    // The face limit per frame, and a limit of zero.
    task automatic test_face_limit();
        wait_drained();
        set_config(16'd640, 16'd480, 16'd1000, 16'd2);
        send_record(mk_rec(1'b1, 5000, 100, 100, 9000, 9000));
        send_record(mk_rec(1'b0, 5000, 20000, 20000, 30000, 40000));
        send_record(mk_rec(1'b0, 5000, 40000, 10000, 50000, 30000));
        send_record(mk_rec(1'b1, 5000, 60000, 60000, 65000, 65000));
        wait_drained();
        set_config(16'd640, 16'd480, 16'd1000, 16'd0);
        send_record(mk_rec(1'b1, 65535, 100, 100, 9000, 9000));
        send_record(mk_rec(1'b0, 65535, 100, 100, 9000, 9000));
    endtask

    // Random records over a range of settings, the extremes among them.
    task automatic test_random_settings();
        run_phase(16'd640, 16'd480, 16'd45875, 16'd16, 200, 12);
        run_phase(16'd16, 16'd16, 16'd0, 16'd64, 150, 12);
        run_phase(16'd4096, 16'd4096, 16'd65534, 16'd5, 60, 8);
        run_phase(16'd4096, 16'd16, 16'd12345, 16'd1, 150, 4);
        // Long frames, so that a limit above 64 stops at 64 faces.
        run_phase(16'd1920, 16'd1080, 16'd30000, 16'd127, 250, 200);
        // Zero-sized frame: only the minimum side is left.
        run_phase(16'd0, 16'd0, 16'd1000, 16'd8, 100, 10);
        // Upper write-data bits are set and must be dropped by the register.
        run_phase(16'hFFFF, 16'hE0F0, 16'($urandom), 16'hFFC0, 150, 100);
        run_phase(16'h1000, 16'd640, 16'($urandom), 16'h0FFF, 150, 30);
        run_phase(16'd1280, 16'd720, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(1, 64)), 140, 12);
    endtask

    // The receiver holds off for a long stretch while records keep coming,
    // so the pipeline fills and the input stalls.
    task automatic test_output_backpressure();
        wait_drained();
        set_config(16'd320, 16'd240, 16'd0, 16'd64);
        send_idle_en = 1'b0;
        fork
            begin
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
        join_none
        send_record(mk_rec(1'b1, 65535, 1000, 1000, 20000, 20000));
        repeat (59) begin
            t_det_rec r;
            r = random_record(0);
            r.score = 16'($urandom_range(1, 65535));
            send_record(r);
        end
        send_idle_en = 1'b1;
    endtask

    // A long stretch with no idling on either side.
    task automatic test_streaming_no_idle();
        wait_drained();
        set_config(16'd800, 16'd600, 16'd20000, 16'd64);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        repeat (150) send_record(random_record(20));
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    // Receiver side: check each accepted word against the oldest expected box.
    always @(posedge i_clk) begin : result_check
        t_sq_box want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (box_wr == box_rd) begin
                report_mismatch("unexpected word, data", 0, longint'(o_m_axis_tdata));
            end else begin
                want = box_mem[box_rd % BOX_DEPTH];
                box_rd++;
                if (o_m_axis_tdata[5:0] !== want.face)
                    report_mismatch("face_number", longint'(want.face),
                                    longint'(o_m_axis_tdata[5:0]));
                if (o_m_axis_tdata[18:6] !== want.sq_left)
                    report_mismatch("square_left", longint'(want.sq_left),
                                    longint'(o_m_axis_tdata[18:6]));
                if (o_m_axis_tdata[31:19] !== want.sq_top)
                    report_mismatch("square_top", longint'(want.sq_top),
                                    longint'(o_m_axis_tdata[31:19]));
                if (o_m_axis_tdata[44:32] !== want.sq_right)
                    report_mismatch("square_right", longint'(want.sq_right),
                                    longint'(o_m_axis_tdata[44:32]));
                if (o_m_axis_tdata[57:45] !== want.sq_bottom)
                    report_mismatch("square_bottom", longint'(want.sq_bottom),
                                    longint'(o_m_axis_tdata[57:45]));
            end
        end
    end

    // Receiver pacing. A hold-off request loads a cycle count; tready stays
    // low until it runs out. Otherwise the receiver stalls at random.
    always @(posedge i_clk) begin : ready_drive
        if (!i_rst_n) begin
            hold_left       <= 0;
            i_m_axis_tready <= 1'b0;
        end else if (hold_start) begin
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !(recv_idle_en && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_CAM_WIDTH;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_threshold_and_corners();
        test_face_limit();
        test_random_settings();
        test_output_backpressure();
        test_streaming_no_idle();
        wait_drained();

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
src/fbts_pkg.sv
src/fbts_admit.sv
src/fbts_scale.sv
src/fbts_box.sv
src/fbts_place.sv
src/face_box_threshold_squarer.sv
verif/tb_top.sv
